### design/cpc_pkg.sv
package cpc_pkg;

    localparam int MAC_A_W = 17;
    localparam int MAC_B_W = 15;
    localparam int PROD_W  = MAC_A_W + MAC_B_W;
    localparam int DIST_W  = 33;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [1:0] CFG_EDGE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_ANTIALIAS    = 2'd1;
    localparam logic [1:0] CFG_INVERSE_FILL = 2'd2;

    localparam logic [8:0]               COV_ONE    = 9'd256;
    localparam logic signed [DIST_W-1:0] ROUND_HALF = 33'sd128;
    localparam logic signed [DIST_W-1:0] DIST_HALF  = 33'sd16384;
    localparam logic signed [DIST_W-1:0] DIST_ONE   = 33'sd32768;

    typedef struct packed {
        logic              opcode;
        logic [2:0]        edge_index;
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [23:0] coef_c;
        logic [12:0]       pixel_x;
        logic [12:0]       pixel_y;
        logic [7:0]        in_red;
        logic [7:0]        in_green;
        logic [7:0]        in_blue;
        logic [7:0]        in_alpha;
    } cmd_t;

    typedef struct packed {
        logic [8:0] coverage;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } result_t;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [23:0] c;
    } edge_t;

endpackage

### design/cpc_mac.sv
module cpc_mac (
    input  logic signed [cpc_pkg::MAC_A_W-1:0] op_a,
    input  logic signed [cpc_pkg::MAC_B_W-1:0] op_b,
    input  logic signed [cpc_pkg::DIST_W-1:0]  addend,
    output logic signed [cpc_pkg::DIST_W-1:0]  sum
);

    logic signed [cpc_pkg::PROD_W-1:0] prod;

    assign prod = op_a * op_b;
    assign sum  = cpc_pkg::DIST_W'(prod) + addend;

endmodule

### design/convex_polygon_coverage.sv
// channel   direction  handshake          payload
// command   in         start / busy       cmd (cpc_pkg::cmd_t)
// result    out        done strobe        result (cpc_pkg::result_t)
// config    in         cfg_we             cfg_index, cfg_data
//
// a load transaction writes the edge table when accepted and leaves busy low
// a pixel transaction walks the n active edges (n at most MAX_EDGES) and then the color
// channels: one shared 17x15 multiply-add unit runs three passes per edge
// and four passes for the color channels
// done is high for one cycle; the receiver cannot stall, and result keeps its value until the next pixel's color passes
// rst_n clears the control state and registers but sets antialias on; the edge table is undefined until loaded
module convex_polygon_coverage #(
    parameter int MAX_EDGES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cpc_pkg::cmd_t    cmd,
    output logic             done,
    output cpc_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [3:0]       cfg_data
);

    localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W = $clog2(MAX_EDGES + 1);
    localparam int CMP_W = CNT_W + 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_EDGE_COV,
        S_FINISH,
        S_COLOR
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]       edge_count_reg;
    logic             antialias_reg;
    logic             inverse_fill_reg;

    cpc_pkg::edge_t   edge_tab [MAX_EDGES];
    cpc_pkg::cmd_t    cmd_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]       chan_reg;
    logic [8:0]       acc_reg, acc_next;
    logic signed [cpc_pkg::DIST_W-1:0] d_reg;
    cpc_pkg::result_t result_reg, result_next;
    logic             done_reg, done_next;

    logic             accept;
    logic             load_ok;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] n_next;
    cpc_pkg::edge_t   cur_edge;
    logic [8:0]       edge_cov;
    logic [15:0]      d_clamp;
    logic [16:0]      d_round;
    logic [7:0]       chan_val;
    logic [13:0]      px, py;

    logic signed [cpc_pkg::MAC_A_W-1:0] mac_a;
    logic signed [cpc_pkg::MAC_B_W-1:0] mac_b;
    logic signed [cpc_pkg::DIST_W-1:0]  mac_add;
    logic signed [cpc_pkg::DIST_W-1:0]  mac_sum;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // edge table
    assign wr_idx  = IDX_W'(cmd.edge_index);
    assign load_ok = (6'(cmd.edge_index) < 6'(MAX_EDGES));

    always_ff @(posedge clk)
    begin
        if (accept && cmd.opcode == cpc_pkg::OP_LOAD && load_ok)
        begin
            edge_tab[wr_idx].a <= cmd.coef_a;
            edge_tab[wr_idx].b <= cmd.coef_b;
            edge_tab[wr_idx].c <= cmd.coef_c;
        end
    end

    assign cur_edge = edge_tab[idx_reg[IDX_W-1:0]];

    // active edge count, saturated
    always_comb
    begin
        if (CMP_W'(edge_count_reg) > CMP_W'(MAX_EDGES))
            n_next = CNT_W'(MAX_EDGES);
        else
            n_next = CNT_W'(edge_count_reg);
    end

    // per-edge coverage from the distance
    always_comb
    begin
        if (d_reg < 0)
            d_clamp = 16'd0;
        else if (d_reg > cpc_pkg::DIST_ONE)
            d_clamp = 16'd32768;
        else
            d_clamp = d_reg[15:0];
        d_round = 17'(d_clamp) + 17'd64;
        if (antialias_reg)
            edge_cov = d_round[15:7];
        else if (d_reg >= cpc_pkg::DIST_HALF)
            edge_cov = cpc_pkg::COV_ONE;
        else
            edge_cov = 9'd0;
    end

    always_comb
    begin
        case (chan_reg)
            2'd0:    chan_val = cmd_reg.in_red;
            2'd1:    chan_val = cmd_reg.in_green;
            2'd2:    chan_val = cmd_reg.in_blue;
            default: chan_val = cmd_reg.in_alpha;
        endcase
    end

    assign px = {cmd_reg.pixel_x, 1'b1};
    assign py = {cmd_reg.pixel_y, 1'b1};

    // operand select for the shared multiply-add
    always_comb
    begin
        mac_a   = '0;
        mac_b   = '0;
        mac_add = '0;
        unique case (state_reg)
            S_EDGE_A:
            begin
                mac_a   = cpc_pkg::MAC_A_W'(cur_edge.a);
                mac_b   = $signed({1'b0, px});
                mac_add = $signed({{(cpc_pkg::DIST_W - 31){cur_edge.c[23]}},
                                   cur_edge.c, 7'b0});
            end
            S_EDGE_B:
            begin
                mac_a   = cpc_pkg::MAC_A_W'(cur_edge.b);
                mac_b   = $signed({1'b0, py});
                mac_add = d_reg;
            end
            S_EDGE_COV:
            begin
                mac_a   = $signed({8'b0, acc_reg});
                mac_b   = $signed({6'b0, edge_cov});
                mac_add = cpc_pkg::ROUND_HALF;
            end
            S_COLOR:
            begin
                mac_a   = $signed({9'b0, chan_val});
                mac_b   = $signed({6'b0, acc_reg});
                mac_add = cpc_pkg::ROUND_HALF;
            end
            default:
            begin
                mac_a   = '0;
                mac_b   = '0;
                mac_add = '0;
            end
        endcase
    end

    cpc_mac u_mac (
        .op_a   (mac_a),
        .op_b   (mac_b),
        .addend (mac_add),
        .sum    (mac_sum)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.opcode == cpc_pkg::OP_PIXEL)
                begin
                    idx_next = '0;
                    acc_next = cpc_pkg::COV_ONE;
                    if (n_next == '0)
                        state_next = S_FINISH;
                    else
                        state_next = S_EDGE_A;
                end
            end
            S_EDGE_A:
                state_next = S_EDGE_B;
            S_EDGE_B:
                state_next = S_EDGE_COV;
            S_EDGE_COV:
            begin
                acc_next = mac_sum[16:8];
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == n_reg)
                    state_next = S_FINISH;
                else
                    state_next = S_EDGE_A;
            end
            S_FINISH:
            begin
                if (inverse_fill_reg)
                    acc_next = cpc_pkg::COV_ONE - acc_reg;
                state_next = S_COLOR;
            end
            S_COLOR:
            begin
                result_next.coverage = acc_reg;
                case (chan_reg)
                    2'd0:    result_next.out_red   = mac_sum[15:8];
                    2'd1:    result_next.out_green = mac_sum[15:8];
                    2'd2:    result_next.out_blue  = mac_sum[15:8];
                    default: result_next.out_alpha = mac_sum[15:8];
                endcase
                if (chan_reg == 2'd3)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            n_reg            <= '0;
            chan_reg         <= '0;
            acc_reg          <= '0;
            d_reg            <= '0;
            done_reg         <= 1'b0;
            result_reg       <= '0;
            cmd_reg          <= '0;
            edge_count_reg   <= 4'd0;
            antialias_reg    <= 1'b1;
            inverse_fill_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            if (state_reg == S_EDGE_A || state_reg == S_EDGE_B)
                d_reg <= mac_sum;
            if (state_reg == S_COLOR)
                chan_reg <= chan_reg + 1'b1;
            else
                chan_reg <= '0;
            if (accept && cmd.opcode == cpc_pkg::OP_PIXEL)
            begin
                cmd_reg <= cmd;
                n_reg   <= n_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cpc_pkg::CFG_EDGE_COUNT:   edge_count_reg   <= cfg_data;
                    cpc_pkg::CFG_ANTIALIAS:    antialias_reg    <= cfg_data[0];
                    cpc_pkg::CFG_INVERSE_FILL: inverse_fill_reg <= cfg_data[0];
                    default:                   ;
                endcase
            end
        end
    end

endmodule

### tb/convex_polygon_coverage_tb.sv
`timescale 1ns / 100ps

class cpc_scoreboard;

    localparam int MAX_EDGES = 8;

    cpc_pkg::edge_t   edges [MAX_EDGES];
    logic [3:0]       edge_count;
    logic             antialias;
    logic             inverse_fill;
    cpc_pkg::result_t pending_pixels [$];
    int               errors;

    function new();
        edge_count   = 4'd0;
        antialias    = 1'b1;
        inverse_fill = 1'b0;
        errors       = 0;
        foreach (edges[i])
            edges[i] = '0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [3:0] val);
        case (idx)
            cpc_pkg::CFG_EDGE_COUNT:   edge_count   = val;
            cpc_pkg::CFG_ANTIALIAS:    antialias    = val[0];
            cpc_pkg::CFG_INVERSE_FILL: inverse_fill = val[0];
            default: ;
        endcase
    endfunction

    function logic [7:0] scale_channel(input logic [7:0] ch, input int unsigned cov);
        int unsigned prod;
        prod = (int'(ch) * cov + 128) >> 8;
        return prod[7:0];
    endfunction

    function cpc_pkg::result_t shade_pixel(input cpc_pkg::cmd_t c);
        cpc_pkg::result_t r;
        longint           px;
        longint           py;
        longint           dval;
        int               n;
        int unsigned      acc;
        int unsigned      cov;
        n = (edge_count > MAX_EDGES) ? MAX_EDGES : int'(edge_count);
        px = longint'(c.pixel_x) * 2 + 1;
        py = longint'(c.pixel_y) * 2 + 1;
        acc = 256;
        for (int i = 0; i < n; i++)
        begin
            dval = longint'(edges[i].a) * px + longint'(edges[i].b) * py
                 + longint'(edges[i].c) * 128;
            if (antialias)
            begin
                if (dval < 0)
                    dval = 0;
                if (dval > 32768)
                    dval = 32768;
                cov = int'((dval + 64) >>> 7);
            end
            else
            begin
                cov = (dval >= 16384) ? 256 : 0;
            end
            acc = (acc * cov + 128) >> 8;
        end
        if (inverse_fill)
            acc = 256 - acc;
        r.coverage  = acc[8:0];
        r.out_red   = scale_channel(c.in_red, acc);
        r.out_green = scale_channel(c.in_green, acc);
        r.out_blue  = scale_channel(c.in_blue, acc);
        r.out_alpha = scale_channel(c.in_alpha, acc);
        return r;
    endfunction

    function void note_cmd(input cpc_pkg::cmd_t c);
        if (c.opcode == cpc_pkg::OP_LOAD)
        begin
            if (c.edge_index < MAX_EDGES)
                edges[c.edge_index] = '{a: c.coef_a, b: c.coef_b, c: c.coef_c};
        end
        else
        begin
            pending_pixels.push_back(shade_pixel(c));
        end
    endfunction

    function void check_result(input cpc_pkg::result_t got);
        cpc_pkg::result_t want;
        if (pending_pixels.size() == 0)
        begin
            $error("result with no transaction pending: coverage %0d", got.coverage);
            errors++;
            return;
        end
        want = pending_pixels.pop_front();
        if (got.coverage !== want.coverage)
        begin
            $error("coverage expected %0d actual %0d", want.coverage, got.coverage);
            errors++;
        end
        if (got.out_red !== want.out_red)
        begin
            $error("out_red expected %0d actual %0d", want.out_red, got.out_red);
            errors++;
        end
        if (got.out_green !== want.out_green)
        begin
            $error("out_green expected %0d actual %0d", want.out_green, got.out_green);
            errors++;
        end
        if (got.out_blue !== want.out_blue)
        begin
            $error("out_blue expected %0d actual %0d", want.out_blue, got.out_blue);
            errors++;
        end
        if (got.out_alpha !== want.out_alpha)
        begin
            $error("out_alpha expected %0d actual %0d", want.out_alpha, got.out_alpha);
            errors++;
        end
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction

    function void close();
        if (pending_pixels.size() != 0)
        begin
            $error("%0d pixel results never arrived", pending_pixels.size());
            errors++;
        end
    endfunction

endclass

module convex_polygon_coverage_tb;

    localparam int         MAX_EDGES      = 8;
    localparam int         TARGET_ITEMS   = 1850;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] CFG_UNUSED     = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cpc_pkg::cmd_t    cmd;
    logic             done;
    cpc_pkg::result_t result;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [3:0]       cfg_data;

    cpc_scoreboard sb;
    int            items;
    int            idle_cycles;
    bit            burst;
    int            cx;
    int            cy;

    convex_polygon_coverage #(
        .MAX_EDGES (MAX_EDGES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("convex_polygon_coverage verification failed");
                $finish;
            end
        end
    end

    function automatic cpc_pkg::cmd_t random_cmd();
        logic [127:0] bits;
        bits = {$urandom(), $urandom(), $urandom(), $urandom()};
        return bits[$bits(cpc_pkg::cmd_t)-1:0];
    endfunction

    function automatic cpc_pkg::cmd_t load_cmd(input logic [2:0] idx, input longint a,
                                               input longint b, input longint c);
        cpc_pkg::cmd_t x;
        x = random_cmd();
        x.opcode     = cpc_pkg::OP_LOAD;
        x.edge_index = idx;
        x.coef_a     = a[15:0];
        x.coef_b     = b[15:0];
        x.coef_c     = c[23:0];
        return x;
    endfunction

    function automatic cpc_pkg::cmd_t pixel_cmd(input int x, input int y,
                                                input logic [31:0] rgba);
        cpc_pkg::cmd_t p;
        p = random_cmd();
        p.opcode   = cpc_pkg::OP_PIXEL;
        p.pixel_x  = x[12:0];
        p.pixel_y  = y[12:0];
        p.in_red   = rgba[31:24];
        p.in_green = rgba[23:16];
        p.in_blue  = rgba[15:8];
        p.in_alpha = rgba[7:0];
        return p;
    endfunction

    // edge whose boundary passes near the polygon center
    function automatic cpc_pkg::cmd_t near_edge(input logic [2:0] idx);
        longint a;
        longint b;
        longint td;
        longint cc;
        if ($urandom_range(3, 0) == 0)
            a = longint'($urandom_range(65535, 0)) - 32768;
        else
            a = longint'($urandom_range(32768, 0)) - 16384;
        if ($urandom_range(3, 0) == 0)
            b = longint'($urandom_range(65535, 0)) - 32768;
        else
            b = longint'($urandom_range(32768, 0)) - 16384;
        td = longint'($urandom_range(163840, 0)) - 65536;
        cc = (td - a * (2 * cx + 1) - b * (2 * cy + 1)) / 128;
        if (cc > 8388607)
            cc = 8388607;
        if (cc < -8388608)
            cc = -8388608;
        return load_cmd(idx, a, b, cc);
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > 8191)
            return 8191;
        return v;
    endfunction

    function automatic cpc_pkg::cmd_t near_pixel();
        return pixel_cmd(clamp_coord(cx + int'($urandom_range(16, 0)) - 8),
                         clamp_coord(cy + int'($urandom_range(16, 0)) - 8), $urandom());
    endfunction

    function automatic int draw_gap();
        return burst ? 0 : int'($urandom_range(19, 0));
    endfunction

    task automatic send(input cpc_pkg::cmd_t c);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        sb.note_cmd(c);
        items++;
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic configure(input logic [3:0] count, input logic aa, input logic inv);
        drain();
        write_reg(cpc_pkg::CFG_EDGE_COUNT, count);
        write_reg(cpc_pkg::CFG_ANTIALIAS, {3'b000, aa});
        write_reg(cpc_pkg::CFG_INVERSE_FILL, {3'b000, inv});
    endtask

    task automatic directed_items();
        // no active edges gives full coverage
        send(pixel_cmd(0, 0, 32'hFFFF_FFFF));
        send(pixel_cmd(8191, 8191, 32'h0000_0000));
        // exactly half, just under half, extremes, diagonal, full
        send(load_cmd(3'd0, 0, 0, 128));
        send(load_cmd(3'd1, 0, 0, 127));
        send(load_cmd(3'd2, 32767, 32767, 8388607));
        send(load_cmd(3'd3, -32768, -32768, -8388608));
        send(load_cmd(3'd4, 16384, -16384, 0));
        send(load_cmd(3'd5, 0, 0, 256));
        send(load_cmd(3'd6, 0, 0, 256));
        send(load_cmd(3'd7, 0, 0, 256));
        configure(4'd1, 1'b1, 1'b0);
        send(pixel_cmd(5, 5, 32'hFF00_8001));
        configure(4'd1, 1'b0, 1'b0);
        send(pixel_cmd(5, 5, 32'hFF00_8001));
        configure(4'd2, 1'b0, 1'b0);
        send(pixel_cmd(77, 1234, 32'hFFFF_FFFF));
        configure(4'd2, 1'b0, 1'b1);
        send(pixel_cmd(77, 1234, 32'hFFFF_FFFF));
        // count above the table size saturates
        configure(4'd15, 1'b1, 1'b1);
        send(pixel_cmd(300, 300, 32'h7F80_01FE));
        configure(4'd8, 1'b1, 1'b0);
        send(pixel_cmd(8191, 0, 32'hFFFF_FFFF));
        send(pixel_cmd(0, 8191, 32'hFFFF_FFFF));
    endtask

    task automatic random_phase();
        logic [3:0]    count;
        int            npix;
        cpc_pkg::cmd_t c;
        case ($urandom_range(9, 0))
            0:       count = 4'd0;
            1:       count = 4'd8;
            2:       count = 4'($urandom_range(15, 9));
            default: count = 4'($urandom_range(8, 1));
        endcase
        configure(count, 1'($urandom()), 1'($urandom()));
        if ($urandom_range(3, 0) == 0)
            write_reg(CFG_UNUSED, 4'($urandom()));
        burst = ($urandom_range(3, 0) == 0);
        cx = int'($urandom_range(8191, 0));
        cy = int'($urandom_range(8191, 0));
        for (int i = 0; i < MAX_EDGES; i++)
        begin
            if ($urandom_range(7, 0) == 0)
                c = load_cmd(3'(i), $urandom(), $urandom(), $urandom());
            else
                c = near_edge(3'(i));
            send(c);
        end
        npix = int'($urandom_range(80, 40));
        for (int i = 0; i < npix; i++)
        begin
            case ($urandom_range(19, 0))
                0:       c = near_edge(3'($urandom()));
                1:       c = load_cmd(3'($urandom()), $urandom(), $urandom(), $urandom());
                2, 3:    c = pixel_cmd(int'($urandom_range(8191, 0)),
                                       int'($urandom_range(8191, 0)), $urandom());
                default: c = near_pixel();
            endcase
            send(c);
            if ($urandom_range(29, 0) == 0)
                drain();
        end
    endtask

    initial
    begin
        sb          = new();
        items       = 0;
        idle_cycles = 0;
        burst       = 1'b0;
        cx          = 0;
        cy          = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_index   = cpc_pkg::CFG_EDGE_COUNT;
        cfg_data    = 4'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_items();
        while (items < TARGET_ITEMS)
            random_phase();

        drain();
        sb.close();
        if (sb.errors == 0)
            $display("convex_polygon_coverage verification clean");
        else
            $display("convex_polygon_coverage verification failed");
        $finish;
    end

endmodule
